// ===== rtl/soe_pkg.sv =====
// Shared types and codes for the set operation engine.
// No dependencies.
package soe_pkg;

    localparam int ELEM_W = 32;

    // Request action codes
    localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [1:0] ACT_RUN         = 2'd2;

    // Operation mode codes
    localparam logic [1:0] MODE_INTERSECT = 2'd0;
    localparam logic [1:0] MODE_DIFF      = 2'd1;
    localparam logic [1:0] MODE_SYMDIFF   = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [ELEM_W-1:0] element;
    } t_in_req;

    typedef struct packed {
        logic signed [ELEM_W-1:0] result_value;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } t_out_req;

endpackage

// ===== rtl/soe_store.sv =====
// Element store for the set operation engine: one write port and one
// registered read port. Depends on soe_pkg.
module soe_store
    import soe_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic signed [ELEM_W-1:0]     i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic signed [ELEM_W-1:0]     o_rd_data
);

    logic signed [ELEM_W-1:0] r_mem [DEPTH];
    logic signed [ELEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/set_operation_engine.sv =====
// Set operation engine: two element stores and a sequencer that scans one
// store against the other through a single shared compare. Uses soe_pkg, soe_store.
// A run walks each outer entry against the inner store with the one comparator,
//   one inner entry at a time (read, then compare), and can be held by result-side
//   stalls; symmetric difference makes a second pass with the stores swapped.
// Throughput: one request at a time; input stall is held high during a run.
// Reset (synchronous, active low) clears counts, overflow flag, mode and the
// sequencer; store contents are left undefined.
module set_operation_engine
    import soe_pkg::*;
#(
    parameter int SET_DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data,
    // mode register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_OUTER  = 7'b0000010,
        S_KEY    = 7'b0000100,
        S_INNER  = 7'b0001000,
        S_CMP    = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]    r_mode;
    logic [CW-1:0] r_first_cnt, n_first_cnt;
    logic [CW-1:0] r_second_cnt, n_second_cnt;
    logic          r_dropped, n_dropped;
    logic          r_pass, n_pass;       // 0: first vs second, 1: second vs first
    logic [CW-1:0] r_i, n_i;             // outer index
    logic [CW-1:0] r_j, n_j;             // inner index
    logic signed [ELEM_W-1:0] r_key, n_key;
    logic          r_found, n_found;
    logic signed [ELEM_W-1:0] r_pend, n_pend;   // qualifying element not yet sent
    logic          r_pend_valid, n_pend_valid;
    logic          r_out_valid, n_out_valid;
    t_out_req      r_out, n_out;

    logic                     in_accept;
    logic                     out_free;
    logic                     wr_first, wr_second;
    logic signed [ELEM_W-1:0] first_rd, second_rd;
    logic signed [ELEM_W-1:0] outer_rd, inner_rd;
    logic [CW-1:0]            outer_cnt, inner_cnt;
    logic                     want_in;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Loads append at the current fill count; drop when full.
    assign wr_first  = in_accept && (i_in_data.action == ACT_LOAD_FIRST)
                       && (r_first_cnt != CW'(SET_DEPTH));
    assign wr_second = in_accept && (i_in_data.action == ACT_LOAD_SECOND)
                       && (r_second_cnt != CW'(SET_DEPTH));

    // Roles swap between passes: the outer store is read at i, the inner at j.
    soe_store #(.DEPTH(SET_DEPTH)) u_first (
        .i_clk     (i_clk),
        .i_wr_en   (wr_first),
        .i_wr_addr (r_first_cnt[AW-1:0]),
        .i_wr_data (i_in_data.element),
        .i_rd_addr (r_pass ? r_j[AW-1:0] : r_i[AW-1:0]),
        .o_rd_data (first_rd)
    );

    soe_store #(.DEPTH(SET_DEPTH)) u_second (
        .i_clk     (i_clk),
        .i_wr_en   (wr_second),
        .i_wr_addr (r_second_cnt[AW-1:0]),
        .i_wr_data (i_in_data.element),
        .i_rd_addr (r_pass ? r_i[AW-1:0] : r_j[AW-1:0]),
        .o_rd_data (second_rd)
    );

    assign outer_rd  = r_pass ? second_rd : first_rd;
    assign inner_rd  = r_pass ? first_rd : second_rd;
    assign outer_cnt = r_pass ? r_second_cnt : r_first_cnt;
    assign inner_cnt = r_pass ? r_first_cnt : r_second_cnt;
    // Intersection keeps members; both differences keep non-members.
    assign want_in   = (r_mode == MODE_INTERSECT);

    always_comb begin
        n_state      = r_state;
        n_first_cnt  = r_first_cnt;
        n_second_cnt = r_second_cnt;
        n_dropped    = r_dropped;
        n_pass       = r_pass;
        n_i          = r_i;
        n_j          = r_j;
        n_key        = r_key;
        n_found      = r_found;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        // drop the output request once the consumer takes it
        n_out_valid  = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.action == ACT_LOAD_FIRST) begin
                        if (wr_first) begin
                            n_first_cnt = r_first_cnt + CW'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end else if (i_in_data.action == ACT_LOAD_SECOND) begin
                        if (wr_second) begin
                            n_second_cnt = r_second_cnt + CW'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end else if (i_in_data.action == ACT_RUN) begin
                        n_pass       = 1'b0;
                        n_i          = '0;
                        n_pend_valid = 1'b0;
                        // unused mode code yields only the empty item
                        if (r_mode == MODE_INTERSECT || r_mode == MODE_DIFF ||
                            r_mode == MODE_SYMDIFF) begin
                            n_state = S_OUTER;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_OUTER: begin
                if (r_i >= outer_cnt) begin
                    if (r_mode == MODE_SYMDIFF && !r_pass) begin
                        n_pass = 1'b1;
                        n_i    = '0;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                n_key   = outer_rd;
                n_j     = '0;
                n_found = 1'b0;
                n_state = S_INNER;
            end
            S_INNER: begin
                if (r_j >= inner_cnt) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (inner_rd == r_key) begin
                    n_found = 1'b1;
                    n_state = S_DECIDE;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_INNER;
                end
            end
            S_DECIDE: begin
                if (r_found != want_in) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_OUTER;
                end else if (!r_pend_valid) begin
                    n_pend       = r_key;
                    n_pend_valid = 1'b1;
                    n_i          = r_i + CW'(1);
                    n_state      = S_OUTER;
                end else if (out_free) begin
                    // a newer match exists, so the held one is not last
                    n_out.result_value = r_pend;
                    n_out.last         = 1'b0;
                    n_out.empty_res    = 1'b0;
                    n_out.overflow     = r_dropped;
                    n_out_valid        = 1'b1;
                    n_pend             = r_key;
                    n_i                = r_i + CW'(1);
                    n_state            = S_OUTER;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out.result_value = r_pend_valid ? r_pend : '0;
                    n_out.last         = 1'b1;
                    n_out.empty_res    = !r_pend_valid;
                    n_out.overflow     = r_dropped;
                    n_out_valid        = 1'b1;
                    n_pend_valid       = 1'b0;
                    n_first_cnt        = '0;
                    n_second_cnt       = '0;
                    n_dropped          = 1'b0;
                    n_pass             = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_INTERSECT;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_dropped    <= 1'b0;
            r_pass       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
            r_dropped    <= n_dropped;
            r_pass       <= n_pass;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_key   <= n_key;
        r_found <= n_found;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

endmodule
